### design/skct_pkg.sv
// Package: transfer payload types for the sorted key count table.
`default_nettype none

package skct_pkg;

    // Fixed field widths of the request and response payloads.
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned CNT_W16 = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_spam;
    } skct_req_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [CNT_W16-1:0] spam_count;
        logic [CNT_W16-1:0] normal_count;
        logic               was_new;
        logic               table_full;
    } skct_rsp_t;

endpackage

`default_nettype wire

### design/skct_if.sv
// Interfaces: valid/ready request and response channels.
`default_nettype none

interface skct_req_if
    import skct_pkg::*;
;
    logic      valid;
    logic      ready;
    skct_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface skct_rsp_if
    import skct_pkg::*;
;
    logic      valid;
    logic      ready;
    skct_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/sorted_key_count_table.sv
// Top level: sorted key table with binary search, saturating counts and shift insert.
//
//   channel | dir | payload                                              | transfer when
//   --------+-----+------------------------------------------------------+----------------
//   req     | in  | key[31:0], is_spam                                   | valid & ready
//   rsp     | out | position[7:0], spam_count, normal_count, was_new,    | valid & ready
//           |     | table_full                                           |
//
// Sequence: accept, then a SEARCH/PROBE pair per search probe (up to ceil(log2(used+1))
//   probes), SEARCH and CHECK to settle the bound and fetch the candidate, then DONE on a
//   hit or a full table; on an insert SHIFT sweeps the (used - pos) entries up, INSERT
//   writes the new entry and DONE loads the response.
//   All entry reads and writes go through the one RAM port pair, which sets the pace.
// Reset: rst_n is asynchronous, clears the sequencer, fill count and output valid.
//   The RAM is not cleared; only entries below the fill count are ever used.
// Stalls: req.ready is high only while idle. A finished response waits in the
//   output register; the next request is taken meanwhile and only its own
//   completion holds until the response register frees up.
`default_nettype none

module sorted_key_count_table
    import skct_pkg::*;
#(
    parameter int unsigned ENTRIES    = 256,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    skct_req_if.sink  req,
    skct_rsp_if.source rsp
);

    localparam int unsigned ADDR_W = $clog2(ENTRIES);
    localparam int unsigned IDX_W  = $clog2(ENTRIES + 1);
    localparam int unsigned ENT_W  = KEY_BITS + 2 * COUNT_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_PROBE  = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] shift_reg, shift_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic [IDX_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  spam_reg, spam_next;
    logic [COUNT_BITS-1:0] res_spam_reg, res_spam_next;
    logic [COUNT_BITS-1:0] res_norm_reg, res_norm_next;
    logic                  res_new_reg, res_new_next;
    logic                  res_full_reg, res_full_next;
    skct_rsp_t             out_data_reg, out_data_next;

    // RAM port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_wa;
    logic [ENT_W-1:0]  ram_wd;
    logic [IDX_W-1:0]  ram_ra;
    logic [ENT_W-1:0]  ram_rd;

    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_spam;
    logic [COUNT_BITS-1:0] rd_norm;
    logic [COUNT_BITS-1:0] spam_inc;
    logic [COUNT_BITS-1:0] norm_inc;
    logic [IDX_W-1:0]      mid_calc;

    // field extension / truncation helpers
    logic [KEY_BITS+KEY_W-1:0]     key_ext;
    logic [IDX_W+POS_W-1:0]        pos_ext;
    logic [COUNT_BITS+CNT_W16-1:0] spam_ext;
    logic [COUNT_BITS+CNT_W16-1:0] norm_ext;

    assign key_ext  = {{KEY_BITS{1'b0}}, req.data.key};
    assign pos_ext  = {{POS_W{1'b0}}, lo_reg};
    assign spam_ext = {{CNT_W16{1'b0}}, res_spam_reg};
    assign norm_ext = {{CNT_W16{1'b0}}, res_norm_reg};

    assign {rd_key, rd_spam, rd_norm} = ram_rd;

    // saturating increments of the entry just read
    assign spam_inc = (rd_spam == {COUNT_BITS{1'b1}}) ? rd_spam : rd_spam + 1'b1;
    assign norm_inc = (rd_norm == {COUNT_BITS{1'b1}}) ? rd_norm : rd_norm + 1'b1;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    skct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wa[ADDR_W-1:0]),
        .wr_data (ram_wd),
        .rd_addr (ram_ra[ADDR_W-1:0]),
        .rd_data (ram_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        shift_next     = shift_reg;
        wr_pend_next   = wr_pend_reg;
        out_valid_next = out_valid_reg;
        mid_next       = mid_reg;
        wr_addr_next   = wr_addr_reg;
        key_next       = key_reg;
        spam_next      = spam_reg;
        res_spam_next  = res_spam_reg;
        res_norm_next  = res_norm_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        out_data_next  = out_data_reg;

        ram_we = 1'b0;
        ram_wa = lo_reg;
        ram_wd = {key_reg, res_spam_reg, res_norm_reg};
        ram_ra = mid_reg;

        // response register drains independently of the sequencer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next   = key_ext[KEY_BITS-1:0];
                    spam_next  = req.data.is_spam;
                    lo_next    = '0;
                    hi_next    = used_reg;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    ram_ra     = mid_calc;
                    state_next = S_PROBE;
                end
                else
                begin
                    // lower bound found: fetch the candidate entry
                    ram_ra     = lo_reg;
                    state_next = S_CHECK;
                end
            end

            S_PROBE:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end

            S_CHECK:
            begin
                res_new_next  = 1'b0;
                res_full_next = 1'b0;
                if ((lo_reg < used_reg) && (rd_key == key_reg))
                begin
                    res_spam_next = spam_reg ? spam_inc : rd_spam;
                    res_norm_next = spam_reg ? rd_norm : norm_inc;
                    ram_we        = 1'b1;
                    ram_wa        = lo_reg;
                    ram_wd        = {key_reg, res_spam_next, res_norm_next};
                    state_next    = S_DONE;
                end
                else if (used_reg == IDX_W'(ENTRIES))
                begin
                    // new key with no room left: dropped
                    res_spam_next = '0;
                    res_norm_next = '0;
                    res_full_next = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    shift_next   = used_reg;
                    wr_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // one entry per cycle: write last read one slot up, read the next lower
                if (wr_pend_reg)
                begin
                    ram_we = 1'b1;
                    ram_wa = wr_addr_reg;
                    ram_wd = ram_rd;
                end
                if (shift_reg > lo_reg)
                begin
                    ram_ra       = shift_reg - 1'b1;
                    wr_addr_next = shift_reg;
                    wr_pend_next = 1'b1;
                    shift_next   = shift_reg - 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    state_next   = S_INSERT;
                end
            end

            S_INSERT:
            begin
                res_spam_next = {{(COUNT_BITS-1){1'b0}}, spam_reg};
                res_norm_next = {{(COUNT_BITS-1){1'b0}}, ~spam_reg};
                res_new_next  = 1'b1;
                ram_we        = 1'b1;
                ram_wa        = lo_reg;
                ram_wd        = {key_reg, res_spam_next, res_norm_next};
                used_next     = used_reg + 1'b1;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_data_next.position     = res_full_reg ? '0 : pos_ext[POS_W-1:0];
                    out_data_next.spam_count   = spam_ext[CNT_W16-1:0];
                    out_data_next.normal_count = norm_ext[CNT_W16-1:0];
                    out_data_next.was_new      = res_new_reg;
                    out_data_next.table_full   = res_full_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            shift_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            shift_reg     <= shift_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg      <= mid_next;
        wr_addr_reg  <= wr_addr_next;
        key_reg      <= key_next;
        spam_reg     <= spam_next;
        res_spam_reg <= res_spam_next;
        res_norm_reg <= res_norm_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### design/skct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skct_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### tb/sorted_key_count_table_tb.sv
// Testbench for sorted_key_count_table: self-checking, with a table predictor and random flow control.
module sorted_key_count_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skct_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 256;
    localparam logic [CNT_W16-1:0] COUNT_TOP = '1;
    localparam logic [KEY_W-1:0] MID_KEY = 32'h8000_0000;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned SEGMENT      = 50;
    // The tail covers one more item in flight.
    localparam int unsigned TAIL_CYCLES  = 300;
    // About a thousand items plus long idling on both sides.
    localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;
    localparam int unsigned REPORT_CAP   = 50;

    // Predicts the sorted key table and holds the responses still owed by the DUT.
    class token_tally;
        logic [KEY_W-1:0]   key_tab    [TABLE_DEPTH];
        logic [CNT_W16-1:0] spam_tab   [TABLE_DEPTH];
        logic [CNT_W16-1:0] normal_tab [TABLE_DEPTH];
        int unsigned        used;
        skct_rsp_t          due_tallies[$];
        int unsigned        errors, checked, inserts, hits, drops, pinned;

        function logic [CNT_W16-1:0] bump(logic [CNT_W16-1:0] c);
            return (c == COUNT_TOP) ? c : c + 1'b1;
        endfunction

        // First slot whose key is not below k.
        function int unsigned lower_bound(logic [KEY_W-1:0] k);
            int unsigned lo, hi, mid;
            lo = 0;
            hi = used;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_tab[mid] < k)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        // Accepted request: update the table and queue the response it owes.
        function void count_token(logic [KEY_W-1:0] k, logic spam);
            int unsigned at, i;
            skct_rsp_t   owed;
            owed = '0;
            at = lower_bound(k);
            if (at < used && key_tab[at] == k) begin
                if (spam)
                    spam_tab[at] = bump(spam_tab[at]);
                else
                    normal_tab[at] = bump(normal_tab[at]);
                hits++;
            end else if (used >= TABLE_DEPTH) begin
                owed.table_full = 1'b1;
                drops++;
                due_tallies = {due_tallies, owed};
                return;
            end else begin
                for (i = used; i > at; i--) begin
                    key_tab[i]    = key_tab[i-1];
                    spam_tab[i]   = spam_tab[i-1];
                    normal_tab[i] = normal_tab[i-1];
                end
                key_tab[at]    = k;
                spam_tab[at]   = spam ? 1 : 0;
                normal_tab[at] = spam ? 0 : 1;
                used++;
                owed.was_new = 1'b1;
                inserts++;
            end
            owed.position     = at[POS_W-1:0];
            owed.spam_count   = spam_tab[at];
            owed.normal_count = normal_tab[at];
            if (owed.spam_count == COUNT_TOP || owed.normal_count == COUNT_TOP)
                pinned++;
            due_tallies = {due_tallies, owed};
        endfunction

        function void flag(string field, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= REPORT_CAP)
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
            else if (errors == REPORT_CAP + 1)
                $display("further mismatches are counted but not reported");
        endfunction

        function void check_tally(skct_rsp_t got);
            skct_rsp_t want;
            if (due_tallies.size() == 0) begin
                flag("unexpected response, position", 0, got.position);
                return;
            end
            want = due_tallies.pop_front();
            checked++;
            if (got.position !== want.position)
                flag("position", want.position, got.position);
            if (got.spam_count !== want.spam_count)
                flag("spam_count", want.spam_count, got.spam_count);
            if (got.normal_count !== want.normal_count)
                flag("normal_count", want.normal_count, got.normal_count);
            if (got.was_new !== want.was_new)
                flag("was_new", want.was_new, got.was_new);
            if (got.table_full !== want.table_full)
                flag("table_full", want.table_full, got.table_full);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    skct_req_if req_ch ();
    skct_rsp_if rsp_ch ();

    token_tally tally = new();

    // Flow-control knobs: the driver owns src_gaps, sink_stalls feeds the ready process.
    bit              src_gaps    = 1'b0;
    bit              sink_stalls = 1'b0;
    int unsigned     sink_hold   = 0;
    longint unsigned cycle_count = 0;

    sorted_key_count_table #(
        .ENTRIES    (TABLE_DEPTH),
        .KEY_BITS   (KEY_W),
        .COUNT_BITS (CNT_W16)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    // Idle length: half zero, most short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 48);
    endfunction

    // Response side: ready held low for random stretches while stalls are on.
    always @(posedge clk)
    begin
        if (!sink_stalls) begin
            rsp_ch.ready <= 1'b1;
        end else if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            sink_hold = pick_gap();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Response monitor: values sampled at the edge are the ones the DUT saw.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tally.check_tally(rsp_ch.data);
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, tally.due_tallies.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drop valid for a while; called at a clock edge just after a transfer.
    task automatic source_pause(input int unsigned cycles);
        if (cycles != 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // One request transfer. Valid stays high into the next call when there is no gap,
    // so back-to-back requests see a single assignment per edge.
    task automatic offer(input logic [KEY_W-1:0] tok, input logic spam_flag);
        req_ch.valid <= 1'b1;
        req_ch.data  <= skct_req_t'{key: tok, is_spam: spam_flag};
        do
            @(posedge clk);
        while (!req_ch.ready);
        tally.count_token(tok, spam_flag);
        if (src_gaps)
            source_pause(pick_gap());
    endtask

    // Hold the sender until every owed response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tally.due_tallies.size() != 0);
    endtask

    // New keys: clusters at both ends of the key space plus fully random ones.
    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 63);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 63);
            default: return $urandom();
        endcase
    endfunction

    // Mix of new keys, repeats of stored keys, and neighbors of stored keys
    // (these probe the search boundaries). New keys get more weight until full.
    function automatic logic [KEY_W-1:0] random_token();
        int unsigned r, pick, new_share;
        if (tally.used == 0)
            return fresh_key();
        r         = $urandom_range(0, 99);
        pick      = $urandom_range(0, tally.used - 1);
        new_share = (tally.used < TABLE_DEPTH) ? 55 : 35;
        if (r < new_share)
            return fresh_key();
        if (r < new_share + 10)
            return $urandom_range(0, 1) ? tally.key_tab[pick] + 32'd1
                                        : tally.key_tab[pick] - 32'd1;
        return tally.key_tab[pick];
    endfunction

    initial
    begin
        logic [KEY_W-1:0] corner_keys [10];
        int unsigned      i, sent;

        corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001,
                        32'h0000_0001, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h0000_FFFF, 32'hFFFF_0000};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: first key lands at position 0, then hits with both labels
        // back to back. No idling here.
        offer(MID_KEY, 1'b1);
        offer(MID_KEY, 1'b1);
        offer(MID_KEY, 1'b0);
        drain();

        // Directed corners with idling on: insert at front, end and middle,
        // then a hit with the other label; plus hits on MID_KEY with both labels.
        src_gaps = 1'b1;
        sink_stalls <= 1'b1;
        for (i = 0; i < 10; i++) begin
            offer(corner_keys[i], i[0]);
            offer(corner_keys[i], ~i[0]);
        end
        offer(MID_KEY, 1'b1);
        offer(MID_KEY, 1'b0);
        drain();

        // Random part in segments, each with its own idling mix so there are
        // stretches with and without gaps on either side. The table fills up
        // partway through, after which new keys are dropped as full.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            src_gaps = $urandom_range(0, 1);
            sink_stalls <= $urandom_range(0, 1);
            repeat (SEGMENT) offer(random_token(), $urandom_range(0, 1));
            sent += SEGMENT;
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d responses: %0d inserts, %0d hits, %0d keys dropped on a full table",
                 tally.checked, tally.inserts, tally.hits, tally.drops);
        $display("final fill %0d of %0d entries, %0d results at the counter ceiling, %0d mismatches",
                 tally.used, TABLE_DEPTH, tally.pinned, tally.errors);
        if (tally.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
